@@ src/unesc_pkg.sv @@
// ----------------------------------------------------------------------------
// unesc_pkg
// Types, character codes and decode helpers shared by the unescaper modules.
// ----------------------------------------------------------------------------
package unesc_pkg;

   localparam logic [7:0] CH_ESC    = 8'h1B;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LC_E   = 8'h65;
   localparam logic [7:0] CH_UC_E   = 8'h45;
   localparam logic [7:0] CH_LC_N   = 8'h6E;
   localparam logic [7:0] CH_LC_T   = 8'h74;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_THREE  = 8'h33;

   localparam int GRP_MAX = 4;

   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_DOLLAR = 2'd1,
      PH_BODY   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ESC_NONE = 2'd0,
      ESC_BS   = 2'd1,
      ESC_BS0  = 2'd2,
      ESC_BS03 = 2'd3
   } esc_type;

   typedef struct packed {
      logic [GRP_MAX-1:0][7:0] data;
      logic [2:0]              count;
      logic                    has_byte;
      logic                    last;
   } grp_type;

   typedef struct packed {
      grp_type grp;
      esc_type pend;
   } body_type;

   function automatic grp_type put_byte(grp_type g, logic [7:0] b);
      grp_type r;
      r = g;
      if (g.count < 3'(GRP_MAX)) begin
         r.data[g.count[1:0]] = b;
         r.count = g.count + 3'd1;
      end
      return r;
   endfunction

   function automatic body_type fresh_byte(body_type s, logic [7:0] c);
      body_type r;
      r = s;
      if (c == CH_BSLASH) begin
         r.pend = ESC_BS;
      end else begin
         r.grp = put_byte(r.grp, c);
      end
      return r;
   endfunction

   function automatic body_type body_byte(body_type s, logic [7:0] c);
      body_type r;
      r = s;
      case (s.pend)
         ESC_NONE: begin
            r = fresh_byte(s, c);
         end
         ESC_BS: begin
            r.pend = ESC_NONE;
            if (c == CH_LC_E || c == CH_UC_E) begin
               r.grp = put_byte(r.grp, CH_ESC);
            end else if (c == CH_ZERO) begin
               r.pend = ESC_BS0;
            end else if (c == CH_LC_N) begin
               r.grp = put_byte(r.grp, CH_NL);
            end else if (c == CH_LC_T) begin
               r.grp = put_byte(r.grp, CH_TAB);
            end else begin
               r.grp = put_byte(r.grp, CH_BSLASH);
               r.grp = put_byte(r.grp, c);
            end
         end
         ESC_BS0: begin
            if (c == CH_THREE) begin
               r.pend = ESC_BS03;
            end else begin
               r.pend = ESC_NONE;
               r.grp = put_byte(r.grp, CH_BSLASH);
               r.grp = put_byte(r.grp, CH_ZERO);
               r = fresh_byte(r, c);
            end
         end
         ESC_BS03: begin
            r.pend = ESC_NONE;
            if (c == CH_THREE) begin
               r.grp = put_byte(r.grp, CH_ESC);
            end else begin
               r.grp = put_byte(r.grp, CH_BSLASH);
               r.grp = put_byte(r.grp, CH_ZERO);
               r.grp = put_byte(r.grp, CH_THREE);
               r = fresh_byte(r, c);
            end
         end
         default: begin
            r = s;
         end
      endcase
      return r;
   endfunction

   function automatic body_type flush_pending(body_type s);
      body_type r;
      r = s;
      if (s.pend != ESC_NONE) begin
         r.grp = put_byte(r.grp, CH_BSLASH);
      end
      if (s.pend == ESC_BS0 || s.pend == ESC_BS03) begin
         r.grp = put_byte(r.grp, CH_ZERO);
      end
      if (s.pend == ESC_BS03) begin
         r.grp = put_byte(r.grp, CH_THREE);
      end
      r.pend = ESC_NONE;
      return r;
   endfunction

endpackage

@@ src/unesc_front.sv @@
// ----------------------------------------------------------------------------
// unesc_front
// Holds the string state and decodes one input word into a group of up to
// four result bytes.
// ----------------------------------------------------------------------------
module unesc_front import unesc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   output grp_type    grp
);

   phase_type phase_ff, phase_in;
   logic      quoted_ff, quoted_in;
   esc_type   pend_ff, pend_in;
   body_type  work;

   always_comb begin
      phase_in      = phase_ff;
      quoted_in     = quoted_ff;
      work.grp      = '0;
      work.pend     = pend_ff;
      case (phase_ff)
         PH_FIRST: begin
            if (in_byte == CH_DOLLAR) begin
               phase_in = PH_DOLLAR;
               if (in_last) begin
                  work.grp = put_byte(work.grp, CH_DOLLAR);
               end
            end else begin
               phase_in = PH_BODY;
               work = body_byte(work, in_byte);
            end
         end
         PH_DOLLAR: begin
            phase_in = PH_BODY;
            if (in_byte == CH_QUOTE) begin
               quoted_in = 1'b1;
            end else begin
               work.grp = put_byte(work.grp, CH_DOLLAR);
               work = body_byte(work, in_byte);
            end
         end
         default: begin
            if (!(in_last && quoted_ff && in_byte == CH_QUOTE)) begin
               work = body_byte(work, in_byte);
            end
         end
      endcase

      work.grp.has_byte = 1'b1;
      work.grp.last     = in_last;
      pend_in           = work.pend;
      if (in_last) begin
         work = flush_pending(work);
         if (work.grp.count == 3'd0) begin
            work.grp.count    = 3'd1;
            work.grp.has_byte = 1'b0;
         end
         phase_in  = PH_FIRST;
         quoted_in = 1'b0;
         pend_in   = ESC_NONE;
      end
      grp = work.grp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_FIRST;
         quoted_ff <= 1'b0;
         pend_ff   <= ESC_NONE;
      end else if (accept) begin
         phase_ff  <= phase_in;
         quoted_ff <= quoted_in;
         pend_ff   <= pend_in;
      end
   end

endmodule

@@ src/unesc_drain.sv @@
// ----------------------------------------------------------------------------
// unesc_drain
// Result register for one decoded group; hands its bytes out one word per
// cycle while out_ready is high.
// ----------------------------------------------------------------------------
module unesc_drain import unesc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  grp_type    grp,
   output logic       free,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] out_byte,
   output logic       has_byte,
   output logic       out_last
);

   logic [2:0]              count_ff, count_in;
   logic [1:0]              idx_ff, idx_in;
   logic [GRP_MAX-1:0][7:0] data_ff;
   logic                    has_byte_ff;
   logic                    last_ff;
   logic                    at_end;

   assign out_valid = (count_ff != 3'd0);
   assign at_end    = ({1'b0, idx_ff} == (count_ff - 3'd1));
   assign free      = !out_valid || (out_ready && at_end);
   assign out_byte  = has_byte_ff ? data_ff[idx_ff] : 8'h00;
   assign has_byte  = has_byte_ff;
   assign out_last  = last_ff && at_end;

   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      if (out_valid && out_ready) begin
         if (at_end) begin
            count_in = 3'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
      if (load) begin
         count_in = grp.count;
         idx_in   = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
         idx_ff   <= 2'd0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff     <= grp.data;
         has_byte_ff <= grp.has_byte;
         last_ff     <= grp.last;
      end
   end

endmodule

@@ src/escape_sequence_unescaper.sv @@
// Registered: a word's first result appears in the cycle after it is taken.
// Throughput: one input word per cycle while rsp_tready is high and each word
// gives at most one result; a word that expands to more results holds input
// until the single-word result port has drained the result register.
// Reset: synchronous, active high; returns to the start of a string with
// no escape held and the result register empty.
// ----------------------------------------------------------------------------
// escape_sequence_unescaper
// Stream unescaper for dollar-quoted strings with backslash escapes.
// ----------------------------------------------------------------------------
module escape_sequence_unescaper import unesc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tuser,   // [0] has_byte
   output logic       rsp_tlast
);

   grp_type grp;
   logic    accept;

   assign accept = req_tvalid && req_tready;

   unesc_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_tdata),
      .in_last (req_tlast),
      .grp     (grp)
   );

   unesc_drain u_drain (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .grp       (grp),
      .free      (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .has_byte  (rsp_tuser),
      .out_last  (rsp_tlast)
   );

endmodule
